FILE: src/dop_pkg.sv
// Shared result type, option codes and a byte helper for the DHCP option parser.
`timescale 1ns / 1ps

package dop_pkg;

	localparam logic [7:0] TAG_PAD    = 8'd0;
	localparam logic [7:0] TAG_MASK   = 8'd1;
	localparam logic [7:0] TAG_ROUTER = 8'd3;
	localparam logic [7:0] TAG_DNS    = 8'd6;
	localparam logic [7:0] TAG_KIND   = 8'd53;
	localparam logic [7:0] TAG_SERVER = 8'd54;
	localparam logic [7:0] TAG_END    = 8'd255;
	localparam logic [7:0] KIND_ACK   = 8'd5;

	// Value byte counter saturates once past the last captured byte
	localparam logic [2:0] IDX_SAT    = 3'd4;

	typedef struct packed {
		logic [7:0]  message_kind;
		logic        applied;
		logic [31:0] own_address;
		logic [31:0] gateway_address;
		logic [31:0] name_server_address;
		logic [31:0] netmask_value;
		logic [31:0] subnet_value;
		logic [31:0] server_identity;
	} dop_result_t;

	// Replace one byte of a word held in network order (index 0 is bits 31..24)
	function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] idx,
						 input logic [7:0] b);
		logic [31:0] res;
		res = word;
		case (idx)
			2'd0:    res[31:24] = b;
			2'd1:    res[23:16] = b;
			2'd2:    res[15:8]  = b;
			default: res[7:0]   = b;
		endcase
		return res;
	endfunction

endpackage

FILE: src/dop_parse.sv
// Tag/length/value walker with option capture and settings commit.
`timescale 1ns / 1ps

module dop_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data,
	input  logic                 start,
	input  logic [31:0]          offered,
	output logic                 fire,
	output dop_pkg::dop_result_t result
);
	import dop_pkg::*;

	typedef enum logic [1:0] {
		PH_TAG,
		PH_LEN,
		PH_VAL
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  tag_q;
	logic [7:0]  left_q;
	logic [2:0]  idx_q;
	logic [7:0]  kind_q;
	logic [31:0] mask_q;
	logic [31:0] gw_q;
	logic [31:0] dns_q;
	logic [31:0] server_q;
	logic [31:0] own_q;
	logic [31:0] cgw_q;
	logic [31:0] cdns_q;
	logic [31:0] cmask_q;
	logic [31:0] subnet_q;

	logic tag_mode;
	logic is_ack;
	logic low_idx;

	assign tag_mode = start || (phase_q == PH_TAG);
	assign fire     = tag_mode && (data == TAG_END);
	assign is_ack   = (kind_q == KIND_ACK);
	assign low_idx  = (idx_q < IDX_SAT);

	// Result shows the freshly committed values on an ACK
	always_comb begin
		result.message_kind        = kind_q;
		result.applied             = is_ack;
		result.own_address         = is_ack ? offered : own_q;
		result.gateway_address     = is_ack ? gw_q : cgw_q;
		result.name_server_address = is_ack ? dns_q : cdns_q;
		result.netmask_value       = is_ack ? mask_q : cmask_q;
		result.subnet_value        = is_ack ? (offered & mask_q) : subnet_q;
		result.server_identity     = server_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TAG;
			tag_q    <= '0;
			left_q   <= '0;
			idx_q    <= '0;
			kind_q   <= '0;
			mask_q   <= '0;
			gw_q     <= '0;
			dns_q    <= '0;
			server_q <= '0;
			own_q    <= '0;
			cgw_q    <= '0;
			cdns_q   <= '0;
			cmask_q  <= '0;
			subnet_q <= '0;
		end else if (step) begin
			if (tag_mode) begin
				if (data == TAG_PAD) begin
					phase_q <= PH_TAG;
				end else if (data == TAG_END) begin
					phase_q <= PH_TAG;
					if (is_ack) begin
						own_q    <= offered;
						cgw_q    <= gw_q;
						cdns_q   <= dns_q;
						cmask_q  <= mask_q;
						subnet_q <= offered & mask_q;
					end
				end else begin
					tag_q   <= data;
					phase_q <= PH_LEN;
				end
			end else begin
				unique case (phase_q)
					PH_LEN: begin
						left_q  <= data;
						idx_q   <= '0;
						phase_q <= (data == 8'd0) ? PH_TAG : PH_VAL;
					end
					PH_VAL: begin
						if (low_idx) begin
							case (tag_q)
								TAG_MASK:   mask_q   <= put_byte(mask_q, idx_q[1:0], data);
								TAG_ROUTER: gw_q     <= put_byte(gw_q, idx_q[1:0], data);
								TAG_DNS:    dns_q    <= put_byte(dns_q, idx_q[1:0], data);
								TAG_SERVER: server_q <= put_byte(server_q, idx_q[1:0], data);
								TAG_KIND: begin
									if (idx_q == 3'd0)
										kind_q <= data;
								end
								default: ;
							endcase
							idx_q <= idx_q + 3'd1;
						end
						left_q <= left_q - 8'd1;
						// last value byte: expect a tag next
						if (left_q == 8'd1)
							phase_q <= PH_TAG;
					end
					default: phase_q <= PH_TAG;
				endcase
			end
		end
	end

endmodule

FILE: src/dhcp_option_parser.sv
// Top level of the DHCP option parser: input register, walker and result register.
// A byte is captured in the input register and parsed from there; an End result is
// loaded into the result register at the same edge as the End is parsed.
// Throughput: one options byte per cycle; a byte holds only when it is an End
// and the result register is still stalled.
// Reset clears the parse state, the captured and committed values and the offered address.
`timescale 1ns / 1ps

module dhcp_option_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  option_byte,
	input  logic        area_start,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  message_kind,
	output logic        applied,
	output logic [31:0] own_address,
	output logic [31:0] gateway_address,
	output logic [31:0] name_server_address,
	output logic [31:0] netmask_value,
	output logic [31:0] subnet_value,
	output logic [31:0] server_identity
);
	import dop_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic [31:0] offered_q;
	logic        out_valid_q;
	dop_result_t res_q;
	dop_result_t res_next;
	logic        fire;
	logic        adv;

	assign cfg_ready = 1'b1;

	// Hold the stage only when an End meets a result still waiting
	assign adv      = valid_s1 && !(fire && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offered_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			offered_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
			start_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				byte_s1  <= option_byte;
				start_s1 <= area_start;
			end
		end
	end

	dop_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.data    (byte_s1),
		.start   (start_s1),
		.offered (offered_q),
		.fire    (fire),
		.result  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (adv && fire) begin
				out_valid_q <= 1'b1;
				res_q       <= res_next;
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign message_kind        = res_q.message_kind;
	assign applied             = res_q.applied;
	assign own_address         = res_q.own_address;
	assign gateway_address     = res_q.gateway_address;
	assign name_server_address = res_q.name_server_address;
	assign netmask_value       = res_q.netmask_value;
	assign subnet_value        = res_q.subnet_value;
	assign server_identity     = res_q.server_identity;

endmodule
